[rtl/core/modular_arithmetic_unit_macros.svh]
// Assertion helper macros for the modular arithmetic unit.
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mau_pkg.sv]
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types, operation codes and command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package mau_pkg;
  localparam int MOD_BITS = 31;
  localparam int EXT_BITS = MOD_BITS + 1;
  localparam int CNT_BITS = $clog2(MOD_BITS + 2);
  localparam logic [MOD_BITS-1:0] MOD_RESET = {MOD_BITS{1'b1}};

  typedef logic [MOD_BITS-1:0] val_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
    OP_DIV = 3'd3, OP_INV = 3'd4, OP_POW = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED_A, ST_RED_B, ST_DISPATCH, ST_MUL, ST_POW_STEP,
    ST_POW_MUL, ST_INV_DIV, ST_INV_UPD, ST_INV_DONE, ST_FINAL, ST_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture request
    logic red_a;     // reduce a modulo m
    logic red_b;     // reduce b modulo m
    logic simple;    // compute add/sub/trivial result
    logic mul_start; // start a multiply: x*y
    logic mul_sel;   // 0: a*b, 1: a*inv
    logic pow_start; // init power loop
    logic pow_sq;    // start multiply acc*base (or base*base)
    logic pow_sel;   // 0: acc*base, 1: base*base
    logic pow_shift; // shift exponent
    logic inv_start; // init Euclid
    logic div_start; // start r0/r1 divide
    logic inv_upd;   // start q*t1 multiply
    logic inv_fin;   // finish a Euclid round
    logic inv_done;  // evaluate inverse
    logic finalize;  // choose result
    logic take_mul;  // result := multiplier output (power: accumulator)
  } cmd_t;

  typedef struct packed {
    logic busy;      // iterative unit busy
    op_t  op;
    logic e_zero;
    logic e_lsb;
    logic r1_zero;
    logic a_zero;
    logic a_eq_b;
    logic inv_ok;
  } sts_t;
endpackage
`default_nettype wire

[rtl/core/mau_if.sv]
// ----------------------------------------------------------------------------
// mau_req_if / mau_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface mau_req_if import mau_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] req_type;
  val_t operand_a;
  val_t operand_b;
  val_t exponent;
  modport source (output valid, req_type, operand_a, operand_b, exponent, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, exponent, output ready);
endinterface

interface mau_rsp_if import mau_pkg::*; ();
  logic valid;
  logic ready;
  val_t result_value;
  logic div_by_zero;
  modport source (output valid, result_value, div_by_zero, input ready);
  modport sink (input valid, result_value, div_by_zero, output ready);
endinterface
`default_nettype wire

[rtl/core/mau_datapath.sv]
// ----------------------------------------------------------------------------
// mau_datapath
// Operand registers, shift-add multiplier, restoring divider, Euclid state.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_datapath import mau_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire val_t       cfg_mod,
  input  wire logic [2:0] req_type,
  input  wire val_t       operand_a,
  input  wire val_t       operand_b,
  input  wire val_t       exponent,
  output val_t            res,
  output logic            flag
);
  // Work widths carry one extra bit so that sums of two residues fit.
  typedef logic [EXT_BITS-1:0] ext_t;

  logic [2:0] op_r;
  val_t m_r, a_r, b_r, e_r, res_r, inv_r;
  logic flag_r;
  // Shared serial unit (multiply or divide): one bit per cycle.
  logic mode_div_r, busy_r;
  logic [CNT_BITS-1:0] cnt_r;
  val_t x_r, y_r, acc_r;     // multiply: acc += x when y lsb; x doubles
  ext_t rem_r;               // divide: remainder
  val_t q_r, dvd_r, dvs_r;   // quotient, dividend shifting out, divisor
  val_t base_r, pacc_r;      // power
  val_t r0_r, r1_r, t0_r, t1_r;
  // Reduction and power results land on the cycle after the unit idles.
  logic red_a_pend_r, red_b_pend_r, pow_pend_r, pow_base_r;

  val_t m_eff;
  assign m_eff = (cfg_mod < val_t'(2)) ? val_t'(1) : cfg_mod;

  function automatic val_t madd(val_t x, val_t y, val_t m);
    ext_t s;
    s = ext_t'(x) + ext_t'(y);
    if (s >= ext_t'(m)) s = s - ext_t'(m);
    return val_t'(s);
  endfunction

  ext_t rshift;
  assign rshift = {rem_r[EXT_BITS-2:0], dvd_r[MOD_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      red_a_pend_r <= 1'b0; red_b_pend_r <= 1'b0; pow_pend_r <= 1'b0; pow_base_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r <= req_type; m_r <= m_eff; e_r <= exponent;
        a_r <= operand_a; b_r <= operand_b; flag_r <= 1'b0; res_r <= '0;
      end
      // Serial unit start commands.
      if (cmd.red_a || cmd.red_b || cmd.div_start) begin
        mode_div_r <= 1'b1; busy_r <= 1'b1; cnt_r <= CNT_BITS'(MOD_BITS);
        rem_r <= '0; q_r <= '0; dvs_r <= cmd.div_start ? r1_r : m_r;
        dvd_r <= cmd.red_a ? a_r : (cmd.red_b ? b_r : r0_r);
      end
      if (cmd.mul_start || cmd.pow_sq || cmd.inv_upd) begin
        mode_div_r <= 1'b0; busy_r <= 1'b1; cnt_r <= CNT_BITS'(MOD_BITS);
        acc_r <= '0;
        if (cmd.inv_upd) begin
          x_r <= t1_r; y_r <= q_r;   // q <= m already as r0 <= m
        end else if (cmd.pow_sq) begin
          x_r <= base_r; y_r <= cmd.pow_sel ? base_r : pacc_r;
        end else begin
          x_r <= cmd.mul_sel ? inv_r : b_r; y_r <= a_r;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) busy_r <= 1'b0;
        if (mode_div_r) begin
          if (rshift >= ext_t'(dvs_r)) begin
            rem_r <= rshift - ext_t'(dvs_r); q_r <= {q_r[MOD_BITS-2:0], 1'b1};
          end else begin
            rem_r <= rshift; q_r <= {q_r[MOD_BITS-2:0], 1'b0};
          end
          dvd_r <= {dvd_r[MOD_BITS-2:0], 1'b0};
        end else begin
          if (y_r[0]) acc_r <= madd(acc_r, x_r, m_r);
          x_r <= madd(x_r, x_r, m_r);
          y_r <= y_r >> 1;
        end
      end
      // Capture simple and serial results.
      if (cmd.simple) begin
        case (op_r)
          OP_ADD:  res_r <= madd(a_r, b_r, m_r);
          OP_SUB:  res_r <= madd(a_r, (b_r == '0) ? '0 : m_r - b_r, m_r);
          OP_POW:  res_r <= (e_r == '0) ? ((m_r == val_t'(1)) ? '0 : val_t'(1)) : '0;
          default: res_r <= '0;
        endcase
      end
      // Power ends with its product in the running accumulator.
      if (cmd.take_mul) res_r <= (op_r == OP_POW) ? pacc_r : acc_r;
      if (cmd.pow_start) begin
        base_r <= a_r; pacc_r <= (m_r == val_t'(1)) ? '0 : val_t'(1);
      end
      if (cmd.pow_shift) e_r <= e_r >> 1;
      if (cmd.inv_start) begin
        r0_r <= m_r; r1_r <= (op_r == OP_DIV) ? b_r : a_r;
        t0_r <= '0; t1_r <= (m_r == val_t'(1)) ? '0 : val_t'(1);
      end
      if (cmd.inv_fin) begin
        r0_r <= r1_r; r1_r <= val_t'(rem_r);
        t0_r <= t1_r; t1_r <= (t0_r >= acc_r) ? t0_r - acc_r : t0_r + (m_r - acc_r);
      end
      if (cmd.inv_done) inv_r <= t0_r;
      if (cmd.finalize) begin
        if (!sts.inv_ok) begin
          flag_r <= 1'b1; res_r <= '0;
        end else if (op_r == OP_INV) begin
          res_r <= inv_r;
        end else if (a_r == '0) begin
          res_r <= '0;
        end else if (a_r == b_r) begin
          res_r <= (m_r == val_t'(1)) ? '0 : val_t'(1);
        end
      end
      // Land reduction and power results once the serial unit idles.
      if (cmd.red_a) red_a_pend_r <= 1'b1;
      if (cmd.red_b) red_b_pend_r <= 1'b1;
      if (cmd.pow_sq) begin
        pow_pend_r <= 1'b1; pow_base_r <= cmd.pow_sel;
      end
      if (!busy_r && !cmd.red_a && !cmd.red_b && !cmd.pow_sq) begin
        if (red_a_pend_r) a_r <= val_t'(rem_r);
        if (red_b_pend_r) b_r <= val_t'(rem_r);
        if (pow_pend_r) begin
          if (pow_base_r) base_r <= acc_r; else pacc_r <= acc_r;
        end
        red_a_pend_r <= 1'b0; red_b_pend_r <= 1'b0; pow_pend_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.busy     = busy_r || red_a_pend_r || red_b_pend_r || pow_pend_r;
    sts.op       = op_t'(op_r);
    sts.e_zero   = (e_r == '0);
    sts.e_lsb    = e_r[0];
    sts.r1_zero  = (r1_r == '0);
    sts.a_zero   = (a_r == '0);
    sts.a_eq_b   = (a_r == b_r);
    sts.inv_ok   = (r0_r == val_t'(1)) && ((op_r == OP_DIV) ? b_r != '0 : a_r != '0);
  end

  assign res  = res_r;
  assign flag = flag_r;
endmodule
`default_nettype wire

[rtl/core/mau_ctrl.sv]
// ----------------------------------------------------------------------------
// mau_ctrl
// Sequencer: reduce operands, then run the chosen operation.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_ctrl import mau_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      idle,
  output logic      out_load
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_load = 1'b0;
    idle = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: if (in_fire) begin
        cmd.load = 1'b1; state_nxt = ST_RED_A;
      end
      ST_RED_A: begin
        cmd.red_a = 1'b1; state_nxt = ST_RED_B;
      end
      ST_RED_B: if (!sts.busy) begin
        cmd.red_b = 1'b1; state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: if (!sts.busy) begin
        case (sts.op)
          OP_MUL: begin
            cmd.mul_start = 1'b1; state_nxt = ST_MUL;
          end
          OP_DIV, OP_INV: begin
            cmd.inv_start = 1'b1; state_nxt = ST_INV_DIV;
          end
          OP_POW: if (sts.e_zero || sts.a_zero) begin
            cmd.simple = 1'b1; state_nxt = ST_OUT;
          end else begin
            cmd.pow_start = 1'b1; state_nxt = ST_POW_STEP;
          end
          default: begin
            cmd.simple = 1'b1; state_nxt = ST_OUT;
          end
        endcase
      end
      ST_MUL: if (!sts.busy) begin
        cmd.take_mul = 1'b1; state_nxt = ST_OUT;
      end
      ST_POW_STEP: if (!sts.busy) begin
        if (sts.e_zero) begin
          state_nxt = ST_FINAL;
        end else if (sts.e_lsb) begin
          cmd.pow_sq = 1'b1; state_nxt = ST_POW_MUL;
        end else begin
          cmd.pow_sq = 1'b1; cmd.pow_sel = 1'b1; cmd.pow_shift = 1'b1;
        end
      end
      ST_POW_MUL: if (!sts.busy) begin
        cmd.pow_sq = 1'b1; cmd.pow_sel = 1'b1; cmd.pow_shift = 1'b1;
        state_nxt = ST_POW_STEP;
      end
      ST_INV_DIV: if (!sts.busy) begin
        if (sts.r1_zero) begin
          cmd.inv_done = 1'b1; state_nxt = ST_INV_DONE;
        end else begin
          cmd.div_start = 1'b1; state_nxt = ST_INV_UPD;
        end
      end
      ST_INV_UPD: if (!sts.busy) begin
        cmd.inv_upd = 1'b1; state_nxt = ST_FINAL;
      end
      ST_INV_DONE: begin
        cmd.finalize = 1'b1;
        if (sts.op == OP_DIV && sts.inv_ok && !sts.a_zero && !sts.a_eq_b) begin
          cmd.mul_start = 1'b1; cmd.mul_sel = 1'b1; state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_FINAL: if (!sts.busy) begin
        if (sts.op == OP_POW) begin
          cmd.take_mul = 1'b1; state_nxt = ST_OUT;
        end else begin
          cmd.inv_fin = 1'b1; state_nxt = ST_INV_DIV;
        end
      end
      ST_OUT: if (out_free) begin
        out_load = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/modular_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Add, subtract, multiply, divide, invert and power modulo a configured modulus.
// ----------------------------------------------------------------------------
// One request is worked at a time. Operands are first reduced by a bit-serial
// restoring divider. Add and subtract then finish directly; multiply runs on
// the shift-add multiplier; power squares the base for each clear exponent bit
// and multiplies then squares for each set bit (square and conditional
// multiply); invert and divide run extended Euclid with one serial divide and
// one serial multiply per round. Reduction, multiply, power and Euclid share
// the one serial unit. A finished result waits in the output register, so the
// next request can be taken in the cycle after it loads.
// The modulus is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module modular_arithmetic_unit import mau_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_wr_en,
  input  wire val_t  cfg_wr_data,
  mau_req_if.sink    in_ch,
  mau_rsp_if.source  out_ch
);
  val_t mod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= MOD_RESET;
    else if (cfg_wr_en) mod_r <= cfg_wr_data;
  end

  cmd_t cmd;
  sts_t sts;
  logic idle, out_load, in_fire, out_free;
  val_t res;
  logic flag;

  // Accept only when the sequencer sits idle.
  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Output register: free when empty or being drained this cycle.
  logic out_valid_r;
  val_t out_res_r;
  logic out_flag_r;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1; out_res_r <= res; out_flag_r <= flag;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.div_by_zero = out_flag_r;

  mau_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .idle, .out_load
  );

  mau_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_mod(mod_r),
    .req_type(in_ch.req_type), .operand_a(in_ch.operand_a),
    .operand_b(in_ch.operand_b), .exponent(in_ch.exponent), .res, .flag
  );
endmodule
`default_nettype wire

[rtl/core/mau_checker.sv]
// ----------------------------------------------------------------------------
// mau_checker
// Port-level checks for the modular arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_arithmetic_unit_macros.svh"
module mau_checker import mau_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire val_t out_result,
  input wire logic out_flag
);
  `MAU_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after accept")
  `MAU_ASSERT_IMPL(a_flag_zero, clk, rst_n, out_valid && out_flag, out_result == '0, "flag with nonzero result")
  `MAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result), "result dropped")
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result(out_ch.result_value), .out_flag(out_ch.div_by_zero)
);
`default_nettype wire

[tb/sv/modular_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_tb
// Self-checking bench for the modular arithmetic unit: directed corner cases,
// then random requests under several modulus settings and idle/stall mixes,
// each result checked against an in-bench model of the residue arithmetic.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_tb import mau_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_CYCLES = 60000;
  localparam int          DRAIN_CYCLES    = 200;
  localparam val_t        ALL_ONES        = {MOD_BITS{1'b1}};
  localparam logic [2:0]  OP_BAD6         = 3'd6;
  localparam logic [2:0]  OP_BAD7         = 3'd7;

  typedef struct {
    val_t value;
    logic dbz;
  } residue_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  val_t cfg_wr_data;

  mau_req_if req_ch ();
  mau_rsp_if rsp_ch ();

  modular_arithmetic_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch)
  );

  // Bench copy of the modulus register and the expected-result store.
  val_t            field_modulus;
  residue_result_t pending_results[$];
  int              mismatch_count = 0;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Residue arithmetic model
  // ---------------------------------------------------------------------------
  function automatic longint unsigned eff_modulus(val_t m);
    return (m < 2) ? 64'd1 : longint'(m);
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base,
                                              longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  // Extended Euclid; ok stays 0 when x has no inverse (zero or shared factor).
  function automatic longint unsigned inv_mod(longint unsigned x, longint unsigned m,
                                              output bit ok);
    longint r0, r1, t0, t1, q, tmp;
    r0 = longint'(m);
    r1 = longint'(x);
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q   = r0 / r1;
      tmp = r0 - q * r1;
      r0  = r1;
      r1  = tmp;
      tmp = t0 - q * t1;
      t0  = t1;
      t1  = tmp;
    end
    ok = (r0 == 1) && (x != 0);
    t0 = t0 % longint'(m);
    if (t0 < 0) t0 = t0 + longint'(m);
    return longint'(t0);
  endfunction

  function automatic residue_result_t compute_residue(logic [2:0] op, val_t a_raw,
                                                      val_t b_raw, val_t e_raw,
                                                      val_t modulus);
    residue_result_t r;
    longint unsigned m, a, b, inv;
    bit ok;
    m = eff_modulus(modulus);
    a = longint'(a_raw) % m;
    b = longint'(b_raw) % m;
    r.value = '0;
    r.dbz   = 1'b0;
    case (op)
      OP_ADD: r.value = val_t'((a + b) % m);
      OP_SUB: r.value = val_t'((a + m - b) % m);
      OP_MUL: r.value = val_t'((a * b) % m);
      OP_DIV: begin
        inv = inv_mod(b, m, ok);
        if (!ok) r.dbz = 1'b1;
        else if (a == 0) r.value = '0;
        else if (a == b) r.value = val_t'(1 % m);
        else r.value = val_t'((a * inv) % m);
      end
      OP_INV: begin
        inv = inv_mod(a, m, ok);
        if (!ok) r.dbz = 1'b1;
        else r.value = val_t'(inv);
      end
      OP_POW: begin
        if (e_raw == 0) r.value = val_t'(1 % m);
        else if (a == 0) r.value = '0;
        else r.value = val_t'(pow_mod(a, longint'(e_raw), m));
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, checking against the oldest expectation, and the
  // watchdog that ends a hung run.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    residue_result_t exp_r;
    if (rst_n) begin
      // Count cycles with no transaction on either channel.
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("modular_arithmetic_unit_tb: errors");
        $finish;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d dbz=%0b", $time,
                   rsp_ch.result_value, rsp_ch.div_by_zero);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_r = pending_results.pop_front();
          if (rsp_ch.result_value !== exp_r.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time,
                     exp_r.value, rsp_ch.result_value);
            mismatch_count <= mismatch_count + 1;
          end
          if (rsp_ch.div_by_zero !== exp_r.dbz) begin
            $display("%0t: div_by_zero expected %0b actual %0b", $time,
                     exp_r.dbz, rsp_ch.div_by_zero);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Send one request; called at a rising edge, returns at the edge that accepts it.
  // Valid is left high so back-to-back requests never drop it within one step.
  task automatic send_request(logic [2:0] op, val_t a, val_t b, val_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= op;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    req_ch.exponent  <= e;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(compute_residue(op, a, b, e, field_modulus));
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the modulus while the unit is idle.
  task automatic write_modulus(val_t m);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    field_modulus = m;
    @(posedge clk);
  endtask

  // Operand biased toward the interesting residues; sometimes above the modulus.
  function automatic val_t pick_operand();
    longint unsigned m;
    m = eff_modulus(field_modulus);
    case ($urandom_range(9))
      0:       return '0;
      1:       return val_t'(m - 1);
      2:       return val_t'($urandom);
      3:       return val_t'($urandom_range(3));
      default: return val_t'({$urandom, $urandom} % m);
    endcase
  endfunction

  // Mostly short exponents keep power requests fast; a few span all 31 bits.
  function automatic val_t pick_exponent();
    int w;
    w = ($urandom_range(9) == 0) ? MOD_BITS : $urandom_range(8);
    if ($urandom_range(15) == 0) return '0;
    return val_t'($urandom) & (ALL_ONES >> (MOD_BITS - w));
  endfunction

  task automatic send_random(int count);
    logic [2:0] op;
    repeat (count) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                     : 3'($urandom_range(5));
      send_request(op, pick_operand(), pick_operand(), pick_exponent());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Corner cases at the reset modulus (2^31-1).
  task automatic test_directed();
    val_t mx;
    mx = ALL_ONES - 1;
    send_request(OP_ADD, mx, mx, '0);
    send_request(OP_ADD, ALL_ONES, 31'd5, ALL_ONES);    // operand reduces to zero
    send_request(OP_SUB, '0, 31'd1, '0);
    send_request(OP_SUB, mx, mx, '0);
    send_request(OP_MUL, mx, mx, '0);
    send_request(OP_MUL, '0, mx, '0);
    send_request(OP_DIV, 31'd12345, '0, '0);            // zero divisor
    send_request(OP_DIV, 31'd777, 31'd777, '0);         // equal operands
    send_request(OP_DIV, '0, 31'd3, '0);
    send_request(OP_DIV, 31'd1000, 31'd7, '0);
    send_request(OP_INV, '0, ALL_ONES, ALL_ONES);       // invert zero
    send_request(OP_INV, 31'd1, '0, '0);
    send_request(OP_INV, mx, ALL_ONES, ALL_ONES);
    send_request(OP_POW, '0, ALL_ONES, '0);             // zero to the zero
    send_request(OP_POW, 31'd5, '0, '0);
    send_request(OP_POW, '0, '0, 31'd7);                // zero base
    send_request(OP_POW, 31'd2, '0, ALL_ONES);
    send_request(OP_POW, mx, mx, ALL_ONES - 1);
    send_request(OP_BAD6, mx, mx, ALL_ONES);
    send_request(OP_BAD7, 31'd3, 31'd4, 31'd5);
  endtask

  // Degenerate moduli: zero and one act as one, two is the smallest field.
  task automatic test_tiny_moduli();
    write_modulus('0);
    send_request(OP_INV, 31'd9, '0, '0);
    send_request(OP_DIV, 31'd3, 31'd4, '0);
    send_request(OP_POW, 31'd3, '0, '0);
    send_random(6);
    write_modulus(31'd1);
    send_random(8);
    write_modulus(31'd2);
    send_request(OP_INV, 31'd3, '0, '0);
    send_random(10);
  endtask

  // Composite modulus: divisors sharing a factor are not invertible.
  task automatic test_composite_modulus();
    write_modulus(31'd15);
    send_request(OP_INV, 31'd6, '0, '0);
    send_request(OP_DIV, 31'd7, 31'd10, '0);
    send_request(OP_DIV, 31'd7, 31'd4, '0);
    send_random(20);
  endtask

  // Random requests through each idle/stall mix.
  task automatic test_random_traffic(val_t m, int count);
    write_modulus(m);
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(count);
    send_idle_pct = 45; recv_stall_pct = 0;  send_random(count);
    send_idle_pct = 0;  recv_stall_pct = 45; send_random(count);
    send_idle_pct = 9;  recv_stall_pct = 9;  send_random(count);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= OP_ADD;
    req_ch.operand_a   <= '0;
    req_ch.operand_b   <= '0;
    req_ch.exponent    <= '0;
    field_modulus      = MOD_RESET;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_tiny_moduli();
    test_composite_modulus();
    test_random_traffic(31'd13, 10);
    test_random_traffic(31'd65521, 10);
    test_random_traffic(ALL_ONES, 29);
    test_random_traffic(31'h4000_0000 + 31'd1, 6);      // composite, top bit set
    write_modulus(MOD_RESET);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("modular_arithmetic_unit_tb: clean");
    else
      $display("modular_arithmetic_unit_tb: errors");
    $finish;
  end
endmodule
